[hw/rtl/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[hw/rtl/bdf_pkg.sv]
// shared constants, types and weight tables of the decimal formatter
package bdf_pkg;

    localparam int MAX_WIDTH = 16;
    localparam int NDIG      = 10;
    localparam int NSTEP     = 35;
    localparam int IN_W      = 5;
    localparam int IDX_W     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int NCH_W     = $clog2(MAX_WIDTH + 1);
    localparam int CLAMP_W   = (NCH_W > IN_W) ? NCH_W : IN_W;
    localparam int KW        = (NCH_W > 4) ? NCH_W : 4;
    localparam int SEL_W     = ((IDX_W > 4) ? IDX_W : 4) + 1;
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = $clog2(QDEPTH + 1);

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NULL  = 8'h00;

    // leading weight of each decade but the units, top decade first
    localparam logic [31:0] DECADE_WEIGHT [0:NDIG-2] = '{
        32'd4000000000, 32'd800000000, 32'd80000000, 32'd8000000, 32'd800000,
        32'd80000, 32'd8000, 32'd800, 32'd80
    };

    typedef logic [NDIG-1:0][3:0] digits_t;

    typedef struct packed {
        digits_t            digits;
        logic [3:0]         count;
        logic [NCH_W-1:0]   nchar;
        logic [IDX_W-1:0]   lead;
        logic [3:0]         base;
        logic [3:0]         ndig;
        logic               zero_fill;
        logic               empty;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // top decade has three steps, every other decade four, but the units digit has none
    function automatic logic [31:0] step_weight(input int s);
        logic [31:0] w;
        if (s < 3)
            w = DECADE_WEIGHT[0] >> s;
        else
            w = DECADE_WEIGHT[((s - 3) >> 2) + 1] >> ((s - 3) & 3);
        return w;
    endfunction

    function automatic int step_digit(input int s);
        int d;
        if (s < 3)
            d = 0;
        else
            d = ((s - 3) >> 2) + 1;
        return d;
    endfunction

    function automatic int step_bit(input int s);
        int b;
        if (s < 3)
            b = 2 - s;
        else
            b = 3 - ((s - 3) & 3);
        return b;
    endfunction

endpackage

[hw/rtl/bdf_front.sv]
// front end: request intake, compare-subtract pipeline and field classification
module bdf_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [31:0]         value,
    input  logic [4:0]          width,
    input  logic [1:0]          fill_mode,
    input  bdf_pkg::q_status_t  qstat,
    output logic                busy,
    output logic                push,
    output bdf_pkg::item_t      item
);

    typedef enum logic [1:0] {
        FILL_ZERO       = 2'd0,
        FILL_BLANK      = 2'd1,
        FILL_LEFT_BLANK = 2'd2,
        FILL_LEFT_NONE  = 2'd3
    } fill_mode_t;

    logic                   vld_reg   [0:bdf_pkg::NSTEP];
    logic [31:0]            acc_reg   [0:bdf_pkg::NSTEP];
    bdf_pkg::digits_t       dig_reg   [0:bdf_pkg::NSTEP];
    logic [4:0]             width_reg [0:bdf_pkg::NSTEP];
    logic [1:0]             mode_reg  [0:bdf_pkg::NSTEP];
    logic                   advance;

    assign advance = !(vld_reg[bdf_pkg::NSTEP] && qstat.full);
    assign busy    = !advance;
    assign push    = vld_reg[bdf_pkg::NSTEP] && !qstat.full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (advance)
        begin
            vld_reg[0] <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && start)
        begin
            acc_reg[0]   <= value;
            dig_reg[0]   <= '0;
            width_reg[0] <= width;
            mode_reg[0]  <= fill_mode;
        end
    end

    for (genvar k = 0; k < bdf_pkg::NSTEP; k++)
    begin : g_step
        localparam logic [31:0] W = bdf_pkg::step_weight(k);
        localparam int          D = bdf_pkg::step_digit(k);
        localparam int          B = bdf_pkg::step_bit(k);
        logic               ge;
        bdf_pkg::digits_t   dig_next;

        assign ge = (acc_reg[k] >= W);

        always_comb
        begin
            dig_next       = dig_reg[k];
            dig_next[D][B] = ge;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k+1] <= 1'b0;
            end
            else if (advance)
            begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                acc_reg[k+1]   <= ge ? (acc_reg[k] - W) : acc_reg[k];
                dig_reg[k+1]   <= dig_next;
                width_reg[k+1] <= width_reg[k];
                mode_reg[k+1]  <= mode_reg[k];
            end
        end
    end

    // classify the finished digits into a field plan for the back end
    always_comb
    begin
        bdf_pkg::digits_t               dg;
        logic [3:0]                     first;
        logic [3:0]                     cnt;
        logic [bdf_pkg::CLAMP_W-1:0]    wx;
        logic [bdf_pkg::NCH_W-1:0]      wc;
        logic [bdf_pkg::KW-1:0]         wk;
        logic [bdf_pkg::KW-1:0]         ck;
        logic [bdf_pkg::KW-1:0]         slop;

        dg = dig_reg[bdf_pkg::NSTEP];
        dg[bdf_pkg::NDIG-1] = acc_reg[bdf_pkg::NSTEP][3:0];
        first = 4'(bdf_pkg::NDIG - 1);
        for (int d = bdf_pkg::NDIG - 2; d >= 0; d--)
        begin
            if (dg[d] != 4'd0)
                first = 4'(d);
        end
        cnt  = 4'(bdf_pkg::NDIG) - first;
        wx   = bdf_pkg::CLAMP_W'(width_reg[bdf_pkg::NSTEP]);
        wc   = (wx > bdf_pkg::CLAMP_W'(bdf_pkg::MAX_WIDTH)) ?
               bdf_pkg::NCH_W'(bdf_pkg::MAX_WIDTH) : bdf_pkg::NCH_W'(wx);
        wk   = bdf_pkg::KW'(wc);
        ck   = bdf_pkg::KW'(cnt);
        slop = wk - ck;

        item.digits    = dg;
        item.count     = cnt;
        item.nchar     = wc;
        item.lead      = '0;
        item.base      = first;
        item.ndig      = cnt;
        item.zero_fill = 1'b0;
        item.empty     = 1'b0;

        if (wc == '0)
        begin
            item.empty = 1'b1;
            item.nchar = bdf_pkg::NCH_W'(1);
        end
        else if (wk <= ck)
        begin
            // low-order digits only
            item.base = 4'(bdf_pkg::NDIG) - 4'(wk);
            item.ndig = 4'(wk);
        end
        else
        begin
            case (fill_mode_t'(mode_reg[bdf_pkg::NSTEP]))
                FILL_ZERO:
                begin
                    item.lead      = bdf_pkg::IDX_W'(slop);
                    item.zero_fill = 1'b1;
                end
                FILL_BLANK:
                begin
                    item.lead = bdf_pkg::IDX_W'(slop);
                end
                FILL_LEFT_BLANK:
                begin
                    item.lead = '0;
                end
                FILL_LEFT_NONE:
                begin
                    item.nchar = bdf_pkg::NCH_W'(ck);
                end
                default:
                begin
                    item.lead = '0;
                end
            endcase
        end
    end

endmodule

[hw/rtl/bdf_queue.sv]
// small register queue between front and back ends
module bdf_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  bdf_pkg::item_t      din,
    input  logic                pop,
    output bdf_pkg::item_t      dout,
    output bdf_pkg::q_status_t  stat
);

    bdf_pkg::item_t                 mem_reg [0:bdf_pkg::QDEPTH-1];
    logic [bdf_pkg::QPTR_W-1:0]     wr_reg;
    logic [bdf_pkg::QPTR_W-1:0]     rd_reg;
    logic [bdf_pkg::QCNT_W-1:0]     cnt_reg;
    logic [bdf_pkg::QCNT_W-1:0]     cnt_next;

    assign stat.full  = (cnt_reg == bdf_pkg::QCNT_W'(bdf_pkg::QDEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign dout       = mem_reg[rd_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + 1'b1;
            if (pop)
                rd_reg <= rd_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= din;
    end

endmodule

[hw/rtl/bdf_back.sv]
// back end: walks one field plan and sends one character per cycle
module bdf_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  bdf_pkg::q_status_t  qstat,
    input  bdf_pkg::item_t      qitem,
    output logic                pop,
    output logic                strobe,
    output logic [7:0]          character,
    output logic                is_last,
    output logic                is_empty,
    output logic [3:0]          digit_count
);

    logic                           act_reg;
    logic                           act_next;
    bdf_pkg::item_t                 cur_reg;
    logic [bdf_pkg::IDX_W-1:0]      idx_reg;
    logic                           last_char;
    logic [7:0]                     ch;
    logic                           strobe_reg;
    logic [7:0]                     char_reg;
    logic                           last_reg;
    logic                           empty_reg;
    logic [3:0]                     count_reg;

    assign last_char = act_reg &&
                       (bdf_pkg::NCH_W'(idx_reg) == cur_reg.nchar - 1'b1);
    assign pop       = !qstat.empty && (!act_reg || last_char);
    assign act_next  = pop ? 1'b1 : (last_char ? 1'b0 : act_reg);

    always_comb
    begin
        logic [bdf_pkg::IDX_W-1:0]  j;
        logic [bdf_pkg::SEL_W-1:0]  jx;
        logic [bdf_pkg::SEL_W-1:0]  sel;
        logic [3:0]                 dsel;

        j    = idx_reg - cur_reg.lead;
        jx   = bdf_pkg::SEL_W'(j);
        sel  = jx + bdf_pkg::SEL_W'(cur_reg.base);
        dsel = (sel[3:0] < 4'(bdf_pkg::NDIG)) ? cur_reg.digits[sel[3:0]] : 4'd0;

        if (cur_reg.empty)
            ch = bdf_pkg::CH_NULL;
        else if (idx_reg < cur_reg.lead)
            ch = cur_reg.zero_fill ? bdf_pkg::CH_ZERO : bdf_pkg::CH_SPACE;
        else if (jx < bdf_pkg::SEL_W'(cur_reg.ndig))
            ch = bdf_pkg::CH_ZERO + {4'd0, dsel};
        else
            ch = bdf_pkg::CH_SPACE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg    <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            act_reg    <= act_next;
            strobe_reg <= act_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= qitem;
            idx_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_reg + 1'b1;
        end
        char_reg  <= ch;
        last_reg  <= last_char;
        empty_reg <= cur_reg.empty;
        count_reg <= cur_reg.count;
    end

    assign strobe      = strobe_reg;
    assign character   = char_reg;
    assign is_last     = last_reg;
    assign is_empty    = empty_reg;
    assign digit_count = count_reg;

endmodule

[hw/rtl/binary_to_decimal_formatter_unit.sv]
// top level of the binary to decimal ASCII field formatter
//
//  channel   handshake            payload
//  request   start / busy         value, width, fill_mode
//  result    strobe (no stall)    character, is_last, is_empty, digit_count
//
// a request passes an input register and 35 compare-subtract stages into a four-deep queue
// the back end sends one character per cycle, max(1, field characters) characters per request,
// up to 16, so the character counter of the back end sets the sustained rate
// a first character passes the stages, the queue and the back end field and output registers
// reset clears valid bits, queue pointers and the back end state, no clearing pass
// busy rises only while the pipeline output waits on a full queue
module binary_to_decimal_formatter_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] value,
    input  logic [4:0]  width,
    input  logic [1:0]  fill_mode,
    output logic        strobe,
    output logic [7:0]  character,
    output logic        is_last,
    output logic        is_empty,
    output logic [3:0]  digit_count
);

    bdf_pkg::q_status_t qstat;
    bdf_pkg::item_t     front_item;
    bdf_pkg::item_t     q_item;
    logic               push;
    logic               pop;

    bdf_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .value      (value),
        .width      (width),
        .fill_mode  (fill_mode),
        .qstat      (qstat),
        .busy       (busy),
        .push       (push),
        .item       (front_item)
    );

    bdf_queue u_queue
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .din    (front_item),
        .pop    (pop),
        .dout   (q_item),
        .stat   (qstat)
    );

    bdf_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .qstat       (qstat),
        .qitem       (q_item),
        .pop         (pop),
        .strobe      (strobe),
        .character   (character),
        .is_last     (is_last),
        .is_empty    (is_empty),
        .digit_count (digit_count)
    );

endmodule

[hw/rtl/bdf_checker.sv]
// port-level checker of the formatter and its bind
`include "assert_macros.svh"

module bdf_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         strobe,
    input logic [7:0]   character,
    input logic         is_last,
    input logic         is_empty,
    input logic [3:0]   digit_count
);

    `ASSERT_IMPLY(a_empty_is_last, clk, rst_n, strobe && is_empty, is_last)
    `ASSERT_IMPLY(a_count_range, clk, rst_n, strobe, digit_count >= 4'd1 && digit_count <= 4'd10)
    `ASSERT_IMPLY(a_char_set, clk, rst_n, strobe && !is_empty, character == bdf_pkg::CH_SPACE || (character >= bdf_pkg::CH_ZERO && character <= 8'h39))
    `ASSERT_NEXT(a_field_unbroken, clk, rst_n, strobe && !is_last, strobe && $stable(digit_count))

endmodule

bind binary_to_decimal_formatter_unit bdf_checker u_bdf_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .strobe      (strobe),
    .character   (character),
    .is_last     (is_last),
    .is_empty    (is_empty),
    .digit_count (digit_count)
);
